// ===== sv/awp_pkg.sv =====
// Shared types and constants for the aspect window placement block.
// No dependencies; used by the channel interfaces and the top level.
package awp_pkg;

   localparam int COORD_BITS  = 14;
   localparam int ASPECT_BITS = 8;
   localparam int OUT_BITS    = 15;
   localparam int PROD_BITS   = COORD_BITS + ASPECT_BITS;
   localparam int CNT_BITS    = $clog2(COORD_BITS + 1);

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = ASPECT_BITS;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [ASPECT_BITS-1:0]     aspect_type;
   typedef logic [OUT_BITS-1:0]        size_type;
   typedef logic signed [OUT_BITS-1:0] offset_type;
   typedef logic [PROD_BITS-1:0]       prod_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ASPECT_WIDTH  = 2'd0,
      CSR_ASPECT_HEIGHT = 2'd1,
      CSR_SCALE_MODE    = 2'd2,
      CSR_ALIGNMENT     = 2'd3
   } csr_index_type;

   localparam logic [1:0] ALIGN_CENTER = 2'd0;
   localparam logic [1:0] ALIGN_LEFT   = 2'd1;
   localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

   localparam aspect_type ASPECT_WIDTH_RESET  = 8'd16;
   localparam aspect_type ASPECT_HEIGHT_RESET = 8'd9;

endpackage

// ===== sv/awp_req_if.sv =====
// Request channel: frame size transactions into the placement block.
// Depends on awp_pkg.
interface awp_req_if import awp_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type frame_width;
   coord_type frame_height;

   modport source (output valid, frame_width, frame_height, input ready);
   modport sink   (input valid, frame_width, frame_height, output ready);
endinterface

// ===== sv/awp_rsp_if.sv =====
// Response channel: placed rectangle transactions out of the placement block.
// Depends on awp_pkg.
interface awp_rsp_if import awp_pkg::*; ();
   logic       valid;
   logic       ready;
   offset_type offset_x;
   offset_type offset_y;
   size_type   out_width;
   size_type   out_height;

   modport source (output valid, offset_x, offset_y, out_width, out_height, input ready);
   modport sink   (input valid, offset_x, offset_y, out_width, out_height, output ready);
endinterface

// ===== sv/aspect_window_placement.sv =====
// Steps: a binary gcd over the aspect terms, two shift-add products and a compare;
// a refit adds a restoring division, a rounding step and two more products; then
// the x and y offsets. A request is accepted only in idle, after the previous
// response is registered. Gcd, product, compare, division and offset arithmetic
// share one adder/subtractor. A finished response waits in its output register.
// Reset: synchronous, active high; registers return to 16:9, full frame, center.
module aspect_window_placement import awp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   awp_req_if.sink                  req_if,
   awp_rsp_if.source                rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD,
      ST_MUL_WA,
      ST_MUL_AH,
      ST_CMP,
      ST_DIV,
      ST_ROUND,
      ST_MUL_RW,
      ST_MUL_RH,
      ST_DIFF_X,
      ST_HALF_X,
      ST_DIFF_Y,
      ST_HALF_Y
   } state_type;

   // configuration
   aspect_type cfg_aw_ff;
   aspect_type cfg_ah_ff;
   logic       cfg_scale_ff;
   logic [1:0] cfg_align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_aw_ff    <= ASPECT_WIDTH_RESET;
         cfg_ah_ff    <= ASPECT_HEIGHT_RESET;
         cfg_scale_ff <= 1'b0;
         cfg_align_ff <= ALIGN_CENTER;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ASPECT_WIDTH:  cfg_aw_ff    <= csr_wdata;
            CSR_ASPECT_HEIGHT: cfg_ah_ff    <= csr_wdata;
            CSR_SCALE_MODE:    cfg_scale_ff <= csr_wdata[0];
            CSR_ALIGNMENT:     cfg_align_ff <= csr_wdata[1:0];
         endcase
      end
   end

   aspect_type aw_eff;
   aspect_type ah_eff;
   assign aw_eff = (cfg_aw_ff == '0) ? ASPECT_BITS'(1) : cfg_aw_ff;
   assign ah_eff = (cfg_ah_ff == '0) ? ASPECT_BITS'(1) : cfg_ah_ff;

   // datapath state
   state_type             state_ff, state_in;
   coord_type             fw_ff, fw_in;
   coord_type             fh_ff, fh_in;
   coord_type             ws_ff, ws_in;
   coord_type             hs_ff, hs_in;
   aspect_type            ga_ff, ga_in;
   aspect_type            gb_ff, gb_in;
   logic                  coprime_ff, coprime_in;
   prod_type              acc_ff, acc_in;
   prod_type              mcand_ff, mcand_in;
   prod_type              prod_ff, prod_in;
   prod_type              diff_ff, diff_in;
   aspect_type            mplier_ff, mplier_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   coord_type             quo_ff, quo_in;
   aspect_type            rem_ff, rem_in;
   aspect_type            den_ff, den_in;
   size_type              wrk_w_ff, wrk_w_in;
   size_type              wrk_h_ff, wrk_h_in;
   offset_type            ox_wrk_ff, ox_wrk_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   offset_type            rsp_ox_ff, rsp_ox_in;
   offset_type            rsp_oy_ff, rsp_oy_in;
   size_type              rsp_w_ff, rsp_w_in;
   size_type              rsp_h_ff, rsp_h_in;

   // shared adder/subtractor
   prod_type             unit_a;
   prod_type             unit_b;
   logic                 unit_inv;
   logic                 unit_cin;
   logic [PROD_BITS:0]   unit_sum;
   logic                 unit_carry;
   logic                 unit_zero;
   logic [OUT_BITS-1:0]  unit_half;

   assign unit_sum   = {1'b0, unit_a} + {1'b0, (unit_inv ? ~unit_b : unit_b)}
                       + {{PROD_BITS{1'b0}}, unit_cin};
   assign unit_carry = unit_sum[PROD_BITS];
   assign unit_zero  = (unit_sum[PROD_BITS-1:0] == '0);
   assign unit_half  = unit_sum[OUT_BITS:1];

   // three-quarter scaling of the incoming frame
   logic [COORD_BITS+1:0] w3;
   logic [COORD_BITS+1:0] h3;
   assign w3 = {2'b00, req_if.frame_width} + {1'b0, req_if.frame_width, 1'b0};
   assign h3 = {2'b00, req_if.frame_height} + {1'b0, req_if.frame_height, 1'b0};

   logic req_fire;
   logic mul_last;
   logic div_last;
   logic out_free;
   logic lt;
   logic fit_match;

   assign req_fire = req_if.valid && req_if.ready;
   assign mul_last = (cnt_ff == CNT_BITS'(ASPECT_BITS - 1));
   assign div_last = (cnt_ff == CNT_BITS'(COORD_BITS - 1));
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign lt       = !unit_carry;
   assign fit_match = unit_zero && coprime_ff && ((ws_ff != '0) || (hs_ff != '0));

   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      ws_in        = ws_ff;
      hs_in        = hs_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      coprime_in   = coprime_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      wrk_w_in     = wrk_w_ff;
      wrk_h_in     = wrk_h_ff;
      ox_wrk_in    = ox_wrk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ox_in    = rsp_ox_ff;
      rsp_oy_in    = rsp_oy_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_h_in     = rsp_h_ff;
      unit_a       = '0;
      unit_b       = '0;
      unit_inv     = 1'b0;
      unit_cin     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fw_in    = req_if.frame_width;
               fh_in    = req_if.frame_height;
               ws_in    = cfg_scale_ff ? w3[COORD_BITS+1:2] : req_if.frame_width;
               hs_in    = cfg_scale_ff ? h3[COORD_BITS+1:2] : req_if.frame_height;
               ga_in    = aw_eff;
               gb_in    = ah_eff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // binary gcd: only "is it one" matters
            unit_a   = PROD_BITS'(ga_ff);
            unit_b   = PROD_BITS'(gb_ff);
            unit_inv = 1'b1;
            unit_cin = 1'b1;
            if (ga_ff == '0 || gb_ff == '0 || (!ga_ff[0] && !gb_ff[0])) begin
               if (ga_ff == '0) begin
                  coprime_in = (gb_ff == ASPECT_BITS'(1));
               end else if (gb_ff == '0) begin
                  coprime_in = (ga_ff == ASPECT_BITS'(1));
               end else begin
                  coprime_in = 1'b0;
               end
               acc_in    = '0;
               mcand_in  = PROD_BITS'(ws_ff);
               mplier_in = ah_eff;
               cnt_in    = '0;
               state_in  = ST_MUL_WA;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (unit_carry) begin
               ga_in = unit_sum[ASPECT_BITS-1:0];
            end else begin
               ga_in = gb_ff;
               gb_in = ga_ff;
            end
         end
         ST_MUL_WA, ST_MUL_AH, ST_MUL_RW, ST_MUL_RH: begin
            // shift-add, one multiplier bit per cycle
            unit_a    = acc_ff;
            unit_b    = mplier_ff[0] ? mcand_ff : '0;
            acc_in    = unit_sum[PROD_BITS-1:0];
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_BITS'(1);
            if (mul_last) begin
               cnt_in = '0;
               unique case (state_ff)
                  ST_MUL_WA: begin
                     prod_in   = unit_sum[PROD_BITS-1:0];
                     acc_in    = '0;
                     mcand_in  = PROD_BITS'(hs_ff);
                     mplier_in = aw_eff;
                     state_in  = ST_MUL_AH;
                  end
                  ST_MUL_AH: begin
                     state_in = ST_CMP;
                  end
                  ST_MUL_RW: begin
                     wrk_w_in  = unit_sum[OUT_BITS-1:0];
                     acc_in    = '0;
                     mcand_in  = PROD_BITS'(quo_ff);
                     mplier_in = ah_eff;
                     state_in  = ST_MUL_RH;
                  end
                  default: begin
                     wrk_h_in = unit_sum[OUT_BITS-1:0];
                     state_in = ST_DIFF_X;
                  end
               endcase
            end
         end
         ST_CMP: begin
            // w*ah against aw*h
            unit_a   = prod_ff;
            unit_b   = acc_ff;
            unit_inv = 1'b1;
            unit_cin = 1'b1;
            if (fit_match) begin
               wrk_w_in = OUT_BITS'(ws_ff);
               wrk_h_in = OUT_BITS'(hs_ff);
               state_in = ST_DIFF_X;
            end else begin
               quo_in   = lt ? ws_ff : hs_ff;
               den_in   = lt ? aw_eff : ah_eff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            unit_a   = PROD_BITS'({rem_ff, quo_ff[COORD_BITS-1]});
            unit_b   = PROD_BITS'(den_ff);
            unit_inv = 1'b1;
            unit_cin = 1'b1;
            if (unit_carry) begin
               rem_in = unit_sum[ASPECT_BITS-1:0];
            end else begin
               rem_in = {rem_ff[ASPECT_BITS-2:0], quo_ff[COORD_BITS-1]};
            end
            quo_in = {quo_ff[COORD_BITS-2:0], unit_carry};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (div_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            unit_a    = PROD_BITS'(quo_ff);
            unit_cin  = (rem_ff != '0);
            quo_in    = unit_sum[COORD_BITS-1:0];
            mcand_in  = PROD_BITS'(unit_sum[COORD_BITS-1:0]);
            mplier_in = aw_eff;
            acc_in    = '0;
            cnt_in    = '0;
            state_in  = ST_MUL_RW;
         end
         ST_DIFF_X: begin
            unit_a   = PROD_BITS'(fw_ff);
            unit_b   = PROD_BITS'(wrk_w_ff);
            unit_inv = 1'b1;
            unit_cin = 1'b1;
            diff_in  = unit_sum[PROD_BITS-1:0];
            state_in = ST_HALF_X;
         end
         ST_HALF_X: begin
            // add one when negative so the shift truncates toward zero
            unit_a   = diff_ff;
            unit_cin = diff_ff[PROD_BITS-1];
            case (cfg_align_ff)
               ALIGN_LEFT:  ox_wrk_in = '0;
               ALIGN_RIGHT: ox_wrk_in = diff_ff[OUT_BITS-1:0];
               default:     ox_wrk_in = unit_half;
            endcase
            state_in = ST_DIFF_Y;
         end
         ST_DIFF_Y: begin
            unit_a   = PROD_BITS'(fh_ff);
            unit_b   = PROD_BITS'(wrk_h_ff);
            unit_inv = 1'b1;
            unit_cin = 1'b1;
            diff_in  = unit_sum[PROD_BITS-1:0];
            state_in = ST_HALF_Y;
         end
         ST_HALF_Y: begin
            unit_a   = diff_ff;
            unit_cin = diff_ff[PROD_BITS-1];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ox_in    = ox_wrk_ff;
               rsp_oy_in    = unit_half;
               rsp_w_in     = wrk_w_ff;
               rsp_h_in     = wrk_h_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fw_ff      <= fw_in;
      fh_ff      <= fh_in;
      ws_ff      <= ws_in;
      hs_ff      <= hs_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      coprime_ff <= coprime_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      prod_ff    <= prod_in;
      diff_ff    <= diff_in;
      mplier_ff  <= mplier_in;
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      wrk_w_ff   <= wrk_w_in;
      wrk_h_ff   <= wrk_h_in;
      ox_wrk_ff  <= ox_wrk_in;
      rsp_ox_ff  <= rsp_ox_in;
      rsp_oy_ff  <= rsp_oy_in;
      rsp_w_ff   <= rsp_w_in;
      rsp_h_ff   <= rsp_h_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.offset_x   = rsp_ox_ff;
   assign rsp_if.offset_y   = rsp_oy_ff;
   assign rsp_if.out_width  = rsp_w_ff;
   assign rsp_if.out_height = rsp_h_ff;

   a_accept_starts_gcd: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_GCD)
      else $error("accepted transaction did not start the gcd loop");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> (ga_ff != '0 || gb_ff != '0))
      else $error("gcd operands both zero");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < den_ff)
      else $error("division remainder not below divisor");

   a_rsp_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HALF_Y)
      else $error("response raised outside the final step");

endmodule

// ===== dv/tb_aspect_window_placement.sv =====
// Testbench for aspect_window_placement: frame sizes in, placed rectangles out, each
// checked against a typed want or a fit-and-align model kept in step with the CSRs.
// Depends on awp_pkg, awp_req_if, awp_rsp_if and the aspect_window_placement RTL.
`timescale 1ns / 1ps

module tb_aspect_window_placement;
   import awp_pkg::*;

   localparam logic [1:0] ALIGN_SPARE = 2'd3;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 88;

   typedef struct packed {
      offset_type offset_x;
      offset_type offset_y;
      size_type   out_width;
      size_type   out_height;
   } placement_type;

   typedef struct packed {
      aspect_type    aspect_w;
      aspect_type    aspect_h;
      logic          scale;
      logic [1:0]    align;
      coord_type     frame_w;
      coord_type     frame_h;
      logic          typed;
      placement_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   awp_req_if req_if ();
   awp_rsp_if rsp_if ();

   aspect_window_placement uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   // shadow of the block's registers
   aspect_type cfg_aspect_w = ASPECT_WIDTH_RESET;
   aspect_type cfg_aspect_h = ASPECT_HEIGHT_RESET;
   logic       cfg_scale = 1'b0;
   logic [1:0] cfg_align = ALIGN_CENTER;

   placement_type placements_due [$];
   int fail_count = 0;
   int send_gap_pct = 25;
   int rsp_stall_pct = 25;
   int stall_left = 0;

   directed_row_type directed_plan [DIRECTED_ROWS] = '{
      '{16, 9, 0, ALIGN_CENTER, 1920, 1080, 1, '{0, 0, 1920, 1080}},
      '{16, 9, 0, ALIGN_CENTER, 1, 1, 1, '{-7, -4, 16, 9}},
      '{16, 9, 0, ALIGN_CENTER, 0, 0, 1, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_CENTER, 16383, 16383, 1, '{0, 3583, 16384, 9216}},
      '{16, 9, 0, ALIGN_CENTER, 16383, 0, 0, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_CENTER, 0, 16383, 0, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_CENTER, 1, 16383, 0, '{0, 0, 0, 0}},
      '{16, 9, 1, ALIGN_CENTER, 1920, 1080, 0, '{0, 0, 0, 0}},
      '{16, 9, 1, ALIGN_CENTER, 1, 1, 0, '{0, 0, 0, 0}},
      '{16, 9, 1, ALIGN_CENTER, 16383, 16383, 0, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_LEFT, 1280, 1024, 0, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_RIGHT, 1280, 1024, 0, '{0, 0, 0, 0}},
      '{16, 9, 0, ALIGN_SPARE, 1280, 1024, 0, '{0, 0, 0, 0}},
      '{0, 0, 0, ALIGN_CENTER, 800, 600, 0, '{0, 0, 0, 0}},
      '{0, 9, 0, ALIGN_RIGHT, 800, 600, 0, '{0, 0, 0, 0}},
      '{255, 255, 0, ALIGN_CENTER, 510, 510, 0, '{0, 0, 0, 0}},
      '{2, 2, 0, ALIGN_LEFT, 1000, 1000, 0, '{0, 0, 0, 0}},
      '{255, 1, 0, ALIGN_RIGHT, 16383, 1, 0, '{0, 0, 0, 0}},
      '{1, 255, 0, ALIGN_CENTER, 1, 16383, 0, '{0, 0, 0, 0}},
      '{255, 255, 1, ALIGN_RIGHT, 16383, 16383, 0, '{0, 0, 0, 0}},
      '{4, 3, 1, ALIGN_CENTER, 1024, 768, 0, '{0, 0, 0, 0}},
      '{1, 1, 0, ALIGN_CENTER, 16383, 16382, 0, '{0, 0, 0, 0}}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_aspect_window_placement NOT OK");
      $finish;
   end

   // expected placement for one frame under the current register shadow
   function automatic placement_type fit_frame(coord_type fw, coord_type fh);
      longint unsigned aw, ah, w, h, a, b, t, rw, rh, r;
      longint dx, dy;
      placement_type p;
      aw = (cfg_aspect_w == 0) ? 1 : cfg_aspect_w;
      ah = (cfg_aspect_h == 0) ? 1 : cfg_aspect_h;
      w = fw;
      h = fh;
      if (cfg_scale) begin
         w = w * 3 / 4;
         h = h * 3 / 4;
      end
      a = w;
      b = h;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      rw = (a != 0) ? w / a : 0;
      rh = (a != 0) ? h / a : 0;
      if (!(rw == aw && rh == ah)) begin
         if (w * ah < aw * h)
            r = (w + aw - 1) / aw;
         else
            r = (h + ah - 1) / ah;
         w = r * aw;
         h = r * ah;
      end
      dx = longint'(fw) - longint'(w);
      dy = longint'(fh) - longint'(h);
      case (cfg_align)
         ALIGN_LEFT:  p.offset_x = '0;
         ALIGN_RIGHT: p.offset_x = offset_type'(dx);
         default:     p.offset_x = offset_type'(dx / 2);
      endcase
      p.offset_y = offset_type'(dy / 2);
      p.out_width = size_type'(w);
      p.out_height = size_type'(h);
      return p;
   endfunction

   function automatic coord_type extreme_coord();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 1;
         2: return coord_type'(COORD_MAX);
         default: return coord_type'($urandom_range(0, COORD_MAX));
      endcase
   endfunction

   // half exact multiples of the aspect, some near misses, extremes, small frames and noise
   task automatic gen_frame(output coord_type fw, output coord_type fh);
      int aw, ah, k, kmax, tw, th, pick;
      aw = (cfg_aspect_w == 0) ? 1 : cfg_aspect_w;
      ah = (cfg_aspect_h == 0) ? 1 : cfg_aspect_h;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         kmax = (cfg_scale ? COORD_MAX * 3 / 4 : COORD_MAX) / ((aw > ah) ? aw : ah);
         if (pick == 0)
            k = kmax;
         else if (pick <= 2)
            k = $urandom_range(1, 8);
         else
            k = $urandom_range(1, kmax);
         tw = k * aw;
         th = k * ah;
         if (cfg_scale) begin
            tw = (4 * tw + 2) / 3;
            th = (4 * th + 2) / 3;
         end
         if (pick == 5) begin
            tw = tw + $urandom_range(0, 2) - 1;
            th = th + $urandom_range(0, 2) - 1;
         end
         fw = coord_type'(tw);
         fh = coord_type'(th);
      end else if (pick == 6) begin
         fw = extreme_coord();
         fh = extreme_coord();
      end else if (pick == 7) begin
         fw = coord_type'($urandom_range(0, 63));
         fh = coord_type'($urandom_range(0, 63));
      end else begin
         fw = coord_type'($urandom_range(0, COORD_MAX));
         fh = coord_type'($urandom_range(0, COORD_MAX));
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (placements_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, aspect_type value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_config(aspect_type aw, aspect_type ah, logic sc, logic [1:0] al);
      drain();
      write_reg(CSR_ASPECT_WIDTH, aw);
      write_reg(CSR_ASPECT_HEIGHT, ah);
      write_reg(CSR_SCALE_MODE, aspect_type'(sc));
      write_reg(CSR_ALIGNMENT, aspect_type'(al));
      csr_we <= 1'b0;
      cfg_aspect_w = aw;
      cfg_aspect_h = ah;
      cfg_scale = sc;
      cfg_align = al;
   endtask

   // valid stays high after a transaction; only a gap or a drain lowers it
   task automatic push_frame(coord_type fw, coord_type fh, logic typed, placement_type want);
      if (send_gap_pct != 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.frame_width <= fw;
      req_if.frame_height <= fh;
      do @(posedge clock); while (!req_if.ready);
      placements_due.push_back(typed ? want : fit_frame(fw, fh));
   endtask

   task automatic check_placement();
      placement_type due;
      if (placements_due.size() == 0) begin
         $error("response transaction with no frame pending");
         fail_count++;
      end else begin
         due = placements_due.pop_front();
         if (rsp_if.offset_x !== due.offset_x) begin
            $error("offset_x expected %0d got %0d", due.offset_x, rsp_if.offset_x);
            fail_count++;
         end
         if (rsp_if.offset_y !== due.offset_y) begin
            $error("offset_y expected %0d got %0d", due.offset_y, rsp_if.offset_y);
            fail_count++;
         end
         if (rsp_if.out_width !== due.out_width) begin
            $error("out_width expected %0d got %0d", due.out_width, rsp_if.out_width);
            fail_count++;
         end
         if (rsp_if.out_height !== due.out_height) begin
            $error("out_height expected %0d got %0d", due.out_height, rsp_if.out_height);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_placement();
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      directed_row_type row;
      coord_type fw, fh;
      aspect_type aw, ah;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.frame_width <= '0;
      req_if.frame_height <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.aspect_w != cfg_aspect_w || row.aspect_h != cfg_aspect_h ||
             row.scale != cfg_scale || row.align != cfg_align)
            set_config(row.aspect_w, row.aspect_h, row.scale, row.align);
         push_frame(row.frame_w, row.frame_h, row.typed, row.want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_config(255, 1, 1'b0, ALIGN_RIGHT);
            1: set_config(1, 255, 1'b1, ALIGN_LEFT);
            2: set_config(255, 255, 1'b1, ALIGN_SPARE);
            default: begin
               case ($urandom_range(0, 5))
                  0: begin aw = 16; ah = 9; end
                  1: begin aw = 4;  ah = 3; end
                  2: begin aw = 8;  ah = 5; end
                  3: begin aw = 21; ah = 9; end
                  default: begin
                     aw = aspect_type'($urandom_range(0, 255));
                     ah = aspect_type'($urandom_range(0, 255));
                  end
               endcase
               set_config(aw, ah, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end
         endcase
         if (phase >= RANDOM_PHASES - 2) begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            send_gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(5, 40);
            rsp_stall_pct = (phase % 4 == 3) ? 0 : $urandom_range(5, 50);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2)
               drain();
            gen_frame(fw, fh);
            push_frame(fw, fh, 1'b0, '0);
         end
      end

      drain();
      repeat (120) @(posedge clock);
      if (fail_count == 0)
         $display("tb_aspect_window_placement OK");
      else
         $display("tb_aspect_window_placement NOT OK");
      $finish;
   end

endmodule

// ===== aspect_window_placement.f =====
sv/awp_pkg.sv
sv/awp_req_if.sv
sv/awp_rsp_if.sv
sv/aspect_window_placement.sv
dv/tb_aspect_window_placement.sv
